@@ sv/iofu_pkg.sv @@
package iofu_pkg;

  // datapath widths of the shared multiplier and the accumulators
  localparam int A_W   = 36;
  localparam int B_W   = 34;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = 56;

  // configuration register indexes
  localparam logic REG_BETA = 1'b0;
  localparam logic REG_DT   = 1'b1;

  // multiplier operand A sources
  typedef enum logic [3:0] {
    A_QW, A_QX, A_QY, A_QZ, A_BETA,
    A_D0, A_D1, A_D2, A_D3,
    A_M0, A_M1, A_M2, A_M3
  } asel_t;

  // multiplier operand B sources
  typedef enum logic [4:0] {
    B_QW, B_QX, B_QY, B_QZ,
    B_FX, B_FY, B_FZ,
    B_G0, B_G1, B_G2, B_G3,
    B_RX, B_RY, B_RZ,
    B_DTLO, B_DTHI,
    B_M0, B_M1, B_M2, B_M3
  } bsel_t;

  // right shift applied to a product before it is accumulated
  typedef enum logic [1:0] {SH_NONE, SH_FRAC, SH_30, SH_16} shsel_t;

  // one multiply-accumulate micro-op
  typedef struct packed {
    asel_t      a;
    bsel_t      b;
    shsel_t     sh;
    logic       neg;
    logic [1:0] shl;
    logic [1:0] dst;
    logic       sq;
  } mop_t;

  // program ranges
  localparam logic [5:0] PC_F      = 6'd0;
  localparam logic [5:0] PC_F_END  = 6'd5;
  localparam logic [5:0] PC_G      = 6'd6;
  localparam logic [5:0] PC_G_END  = 6'd15;
  localparam logic [5:0] PC_C      = 6'd16;
  localparam logic [5:0] PC_C_END  = 6'd19;
  localparam logic [5:0] PC_P      = 6'd20;
  localparam logic [5:0] PC_P_END  = 6'd31;
  localparam logic [5:0] PC_D      = 6'd32;
  localparam logic [5:0] PC_D_END  = 6'd39;
  localparam logic [5:0] PC_SQ     = 6'd40;
  localparam logic [5:0] PC_SQ_END = 6'd43;

  function automatic mop_t mop(asel_t a, bsel_t b, shsel_t sh, logic neg,
                               logic [1:0] shl, logic [1:0] dst, logic sq);
    mop_t m;
    m.a   = a;
    m.b   = b;
    m.sh  = sh;
    m.neg = neg;
    m.shl = shl;
    m.dst = dst;
    m.sq  = sq;
    return m;
  endfunction

  // micro-program: gravity error, gradient, correction, rate term,
  // time step scaling, sum of squares
  function automatic mop_t op_rom(logic [5:0] pc);
    mop_t m;
    case (pc)
      // f = 2*(...) - a_norm, accumulators 1..3
      6'd0:  m = mop(A_QX, B_QZ, SH_FRAC, 1'b0, 2'd1, 2'd1, 1'b0);
      6'd1:  m = mop(A_QW, B_QY, SH_FRAC, 1'b1, 2'd1, 2'd1, 1'b0);
      6'd2:  m = mop(A_QW, B_QX, SH_FRAC, 1'b0, 2'd1, 2'd2, 1'b0);
      6'd3:  m = mop(A_QY, B_QZ, SH_FRAC, 1'b0, 2'd1, 2'd2, 1'b0);
      6'd4:  m = mop(A_QX, B_QX, SH_FRAC, 1'b1, 2'd1, 2'd3, 1'b0);
      6'd5:  m = mop(A_QY, B_QY, SH_FRAC, 1'b1, 2'd1, 2'd3, 1'b0);
      // gradient
      6'd6:  m = mop(A_QX, B_FY, SH_FRAC, 1'b0, 2'd1, 2'd0, 1'b0);
      6'd7:  m = mop(A_QY, B_FX, SH_FRAC, 1'b1, 2'd1, 2'd0, 1'b0);
      6'd8:  m = mop(A_QZ, B_FX, SH_FRAC, 1'b0, 2'd1, 2'd1, 1'b0);
      6'd9:  m = mop(A_QW, B_FY, SH_FRAC, 1'b0, 2'd1, 2'd1, 1'b0);
      6'd10: m = mop(A_QX, B_FZ, SH_FRAC, 1'b1, 2'd2, 2'd1, 1'b0);
      6'd11: m = mop(A_QZ, B_FY, SH_FRAC, 1'b0, 2'd1, 2'd2, 1'b0);
      6'd12: m = mop(A_QW, B_FX, SH_FRAC, 1'b1, 2'd1, 2'd2, 1'b0);
      6'd13: m = mop(A_QY, B_FZ, SH_FRAC, 1'b1, 2'd2, 2'd2, 1'b0);
      6'd14: m = mop(A_QX, B_FX, SH_FRAC, 1'b0, 2'd1, 2'd3, 1'b0);
      6'd15: m = mop(A_QY, B_FY, SH_FRAC, 1'b0, 2'd1, 2'd3, 1'b0);
      // beta times normalized gradient
      6'd16: m = mop(A_BETA, B_G0, SH_30, 1'b0, 2'd0, 2'd0, 1'b0);
      6'd17: m = mop(A_BETA, B_G1, SH_30, 1'b0, 2'd0, 2'd1, 1'b0);
      6'd18: m = mop(A_BETA, B_G2, SH_30, 1'b0, 2'd0, 2'd2, 1'b0);
      6'd19: m = mop(A_BETA, B_G3, SH_30, 1'b0, 2'd0, 2'd3, 1'b0);
      // q times (0, rate), full precision
      6'd20: m = mop(A_QX, B_RX, SH_NONE, 1'b1, 2'd0, 2'd0, 1'b0);
      6'd21: m = mop(A_QY, B_RY, SH_NONE, 1'b1, 2'd0, 2'd0, 1'b0);
      6'd22: m = mop(A_QZ, B_RZ, SH_NONE, 1'b1, 2'd0, 2'd0, 1'b0);
      6'd23: m = mop(A_QW, B_RX, SH_NONE, 1'b0, 2'd0, 2'd1, 1'b0);
      6'd24: m = mop(A_QY, B_RZ, SH_NONE, 1'b0, 2'd0, 2'd1, 1'b0);
      6'd25: m = mop(A_QZ, B_RY, SH_NONE, 1'b1, 2'd0, 2'd1, 1'b0);
      6'd26: m = mop(A_QW, B_RY, SH_NONE, 1'b0, 2'd0, 2'd2, 1'b0);
      6'd27: m = mop(A_QX, B_RZ, SH_NONE, 1'b1, 2'd0, 2'd2, 1'b0);
      6'd28: m = mop(A_QZ, B_RX, SH_NONE, 1'b0, 2'd0, 2'd2, 1'b0);
      6'd29: m = mop(A_QW, B_RZ, SH_NONE, 1'b0, 2'd0, 2'd3, 1'b0);
      6'd30: m = mop(A_QX, B_RY, SH_NONE, 1'b0, 2'd0, 2'd3, 1'b0);
      6'd31: m = mop(A_QY, B_RX, SH_NONE, 1'b1, 2'd0, 2'd3, 1'b0);
      // step times dt, low half first
      6'd32: m = mop(A_D0, B_DTLO, SH_16, 1'b0, 2'd0, 2'd0, 1'b0);
      6'd33: m = mop(A_D0, B_DTHI, SH_NONE, 1'b0, 2'd0, 2'd0, 1'b0);
      6'd34: m = mop(A_D1, B_DTLO, SH_16, 1'b0, 2'd0, 2'd1, 1'b0);
      6'd35: m = mop(A_D1, B_DTHI, SH_NONE, 1'b0, 2'd0, 2'd1, 1'b0);
      6'd36: m = mop(A_D2, B_DTLO, SH_16, 1'b0, 2'd0, 2'd2, 1'b0);
      6'd37: m = mop(A_D2, B_DTHI, SH_NONE, 1'b0, 2'd0, 2'd2, 1'b0);
      6'd38: m = mop(A_D3, B_DTLO, SH_16, 1'b0, 2'd0, 2'd3, 1'b0);
      6'd39: m = mop(A_D3, B_DTHI, SH_NONE, 1'b0, 2'd0, 2'd3, 1'b0);
      // sum of squares for normalization
      6'd40: m = mop(A_M0, B_M0, SH_NONE, 1'b0, 2'd0, 2'd0, 1'b1);
      6'd41: m = mop(A_M1, B_M1, SH_NONE, 1'b0, 2'd0, 2'd0, 1'b1);
      6'd42: m = mop(A_M2, B_M2, SH_NONE, 1'b0, 2'd0, 2'd0, 1'b1);
      6'd43: m = mop(A_M3, B_M3, SH_NONE, 1'b0, 2'd0, 2'd0, 1'b1);
      default: m = mop(A_QW, B_QW, SH_NONE, 1'b0, 2'd0, 2'd0, 1'b0);
    endcase
    return m;
  endfunction

endpackage

@@ sv/imu_orientation_filter_update_unit.sv @@
// IMU orientation filter update unit.
// Input stream (s_*): one request per accelerometer/gyro sample. Output
// stream (m_*): one updated orientation quaternion per request, Q2.30 by
// default. The orientation is kept inside and carried to the next request.
// Configuration: cfg_wen/cfg_addr/cfg_wdata write beta (index 0) and the
// sample period (index 1); write only while the unit is idle.
// Processing time: s_tready is low while a request is worked on. The
// time is set by one shared 36x34 multiplier, a one-bit-per-cycle square
// root and a one-bit-per-cycle divider used by three normalizations,
// plus a one-bit-per-cycle normalizing shift. A zero acceleration skips
// the gradient work.
// Reset: orientation becomes identity, beta and sample period take their
// defaults, both streams go idle.
// Output stall: the result sits in an output register; a new request is
// accepted and processed meanwhile, and its result waits until the
// register is free.
module imu_orientation_filter_update_unit
  import iofu_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each)
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // quat_w, quat_x, quat_y, quat_z (32 bits each)
  output logic [127:0] m_tdata,
  input  logic         cfg_wen,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int DC_W = $clog2(FRAC_BITS + 1);
  localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WAIT, S_POST, S_NABS, S_NSHIFT,
    S_NSQRT, S_NDIV, S_NDONE, S_OUT
  } state_t;

  typedef enum logic [2:0] {PH_F, PH_G, PH_C, PH_P, PH_D, PH_SQ} phase_t;

  typedef enum logic [1:0] {NS_ACC, NS_GRAD, NS_QUAT} nsel_t;

  state_t state;
  phase_t phase;
  nsel_t  nsel;

  logic signed [31:0]      q [4];
  logic signed [15:0]      rx, ry, rz;
  logic [30:0]             beta;
  logic [31:0]             dt;
  logic signed [B_W-1:0]   fv [3];
  logic signed [31:0]      corr [4];
  logic signed [A_W-1:0]   dv [4];
  logic signed [ACC_W-1:0] acc [4];
  logic signed [ACC_W-1:0] nv [4];
  logic [ACC_W-1:0]        mag [4];
  logic [3:0]              nneg;
  logic                    nzero;
  logic signed [31:0]      nres [4];
  logic [63:0]             sumsq;
  logic [63:0]             sx, sres, sbit;
  logic [4:0]              scnt;
  logic [31:0]             nrm;
  logic [33:0]             rem;
  logic [31:0]             quo;
  logic [DC_W-1:0]         dcnt;
  logic [1:0]              ci;
  logic [5:0]              pc, pc_end;
  logic                    mul_vld;
  mop_t                    op_q;
  logic signed [P_W-1:0]   prod;

  // operand selection for the shared multiplier
  mop_t                  op_cur;
  logic signed [A_W-1:0] opa;
  logic signed [B_W-1:0] opb;

  assign op_cur = op_rom(pc);

  always_comb begin
    case (op_cur.a)
      A_QW:    opa = A_W'(q[0]);
      A_QX:    opa = A_W'(q[1]);
      A_QY:    opa = A_W'(q[2]);
      A_QZ:    opa = A_W'(q[3]);
      A_BETA:  opa = A_W'({1'b0, beta});
      A_D0:    opa = dv[0];
      A_D1:    opa = dv[1];
      A_D2:    opa = dv[2];
      A_D3:    opa = dv[3];
      A_M0:    opa = A_W'({1'b0, mag[0][31:0]});
      A_M1:    opa = A_W'({1'b0, mag[1][31:0]});
      A_M2:    opa = A_W'({1'b0, mag[2][31:0]});
      A_M3:    opa = A_W'({1'b0, mag[3][31:0]});
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (op_cur.b)
      B_QW:    opb = B_W'(q[0]);
      B_QX:    opb = B_W'(q[1]);
      B_QY:    opb = B_W'(q[2]);
      B_QZ:    opb = B_W'(q[3]);
      B_FX:    opb = fv[0];
      B_FY:    opb = fv[1];
      B_FZ:    opb = fv[2];
      B_G0:    opb = B_W'(nres[0]);
      B_G1:    opb = B_W'(nres[1]);
      B_G2:    opb = B_W'(nres[2]);
      B_G3:    opb = B_W'(nres[3]);
      B_RX:    opb = B_W'(rx);
      B_RY:    opb = B_W'(ry);
      B_RZ:    opb = B_W'(rz);
      B_DTLO:  opb = B_W'({1'b0, dt[15:0]});
      B_DTHI:  opb = B_W'({1'b0, dt[31:16]});
      B_M0:    opb = B_W'({1'b0, mag[0][31:0]});
      B_M1:    opb = B_W'({1'b0, mag[1][31:0]});
      B_M2:    opb = B_W'({1'b0, mag[2][31:0]});
      B_M3:    opb = B_W'({1'b0, mag[3][31:0]});
      default: opb = '0;
    endcase
  end

  // product post-shift (floor), scale and sign
  logic signed [P_W-1:0]   psh;
  logic signed [ACC_W-1:0] pterm, pterm_s;

  always_comb begin
    case (op_q.sh)
      SH_NONE: psh = prod;
      SH_FRAC: psh = prod >>> FRAC_BITS;
      SH_30:   psh = prod >>> 30;
      SH_16:   psh = prod >>> 16;
      default: psh = prod;
    endcase
    pterm   = ACC_W'(psh) <<< op_q.shl;
    pterm_s = op_q.neg ? -pterm : pterm;
  end

  // normalizing shift range checks
  logic mag_hi, mag_lo;

  assign mag_hi = (|mag[0][ACC_W-1:31]) | (|mag[1][ACC_W-1:31]) |
                  (|mag[2][ACC_W-1:31]) | (|mag[3][ACC_W-1:31]);
  assign mag_lo = ~((|mag[0][ACC_W-1:30]) | (|mag[1][ACC_W-1:30]) |
                    (|mag[2][ACC_W-1:30]) | (|mag[3][ACC_W-1:30]));

  // one square root step
  logic [64:0] rb;
  logic        sge;
  logic [63:0] sres_nx;

  assign rb      = {1'b0, sres} + {1'b0, sbit};
  assign sge     = {1'b0, sx} >= rb;
  assign sres_nx = sge ? ((sres >> 1) + sbit) : (sres >> 1);

  // one restoring division step
  logic        dge;
  logic [33:0] rem_sub;
  logic [31:0] quo_nx;

  assign dge     = rem >= {2'b00, nrm};
  assign rem_sub = dge ? (rem - {2'b00, nrm}) : rem;
  assign quo_nx  = {quo[30:0], dge};

  assign s_tready = (state == S_IDLE);

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_F;
      nsel     <= NS_ACC;
      mul_vld  <= 1'b0;
      m_tvalid <= 1'b0;
      beta     <= 31'd81148039;
      dt       <= 32'd4294967;
      q[0]     <= ONE_Q;
      q[1]     <= '0;
      q[2]     <= '0;
      q[3]     <= '0;
    end else begin
      mul_vld <= 1'b0;

      if (cfg_wen) begin
        case (cfg_addr)
          REG_BETA: beta <= cfg_wdata[30:0];
          REG_DT:   dt   <= cfg_wdata;
          default:  ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // multiply result is registered and lands in the cycle after issue
      prod <= opa * opb;
      op_q <= op_cur;
      if (mul_vld) begin
        if (op_q.sq) begin
          sumsq <= sumsq + prod[63:0];
        end else begin
          acc[op_q.dst] <= acc[op_q.dst] + pterm_s;
        end
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            nv[0] <= '0;
            nv[1] <= ACC_W'($signed(s_tdata[15:0]));
            nv[2] <= ACC_W'($signed(s_tdata[31:16]));
            nv[3] <= ACC_W'($signed(s_tdata[47:32]));
            rx    <= $signed(s_tdata[63:48]);
            ry    <= $signed(s_tdata[79:64]);
            rz    <= $signed(s_tdata[95:80]);
            nsel  <= NS_ACC;
            state <= S_NABS;
          end
        end

        S_MUL: begin
          mul_vld <= 1'b1;
          if (pc == pc_end) begin
            state <= S_WAIT;
          end else begin
            pc <= pc + 6'd1;
          end
        end

        S_WAIT: begin
          state <= S_POST;
        end

        S_POST: begin
          case (phase)
            PH_F: begin
              fv[0] <= acc[1][B_W-1:0];
              fv[1] <= acc[2][B_W-1:0];
              fv[2] <= acc[3][B_W-1:0];
              for (int i = 0; i < 4; i++) acc[i] <= '0;
              pc     <= PC_G;
              pc_end <= PC_G_END;
              phase  <= PH_G;
              state  <= S_MUL;
            end
            PH_G: begin
              for (int i = 0; i < 4; i++) nv[i] <= acc[i];
              nsel  <= NS_GRAD;
              state <= S_NABS;
            end
            PH_C: begin
              for (int i = 0; i < 4; i++) begin
                corr[i] <= acc[i][31:0];
                acc[i]  <= '0;
              end
              pc     <= PC_P;
              pc_end <= PC_P_END;
              phase  <= PH_P;
              state  <= S_MUL;
            end
            PH_P: begin
              for (int i = 0; i < 4; i++) begin
                dv[i]  <= A_W'((acc[i] >>> 13) - ACC_W'(corr[i]));
                acc[i] <= '0;
              end
              pc     <= PC_D;
              pc_end <= PC_D_END;
              phase  <= PH_D;
              state  <= S_MUL;
            end
            PH_D: begin
              for (int i = 0; i < 4; i++) nv[i] <= ACC_W'(q[i]) + (acc[i] >>> 16);
              nsel  <= NS_QUAT;
              state <= S_NABS;
            end
            PH_SQ: begin
              sx    <= sumsq;
              sres  <= '0;
              sbit  <= 64'd1 << 62;
              scnt  <= 5'd31;
              state <= S_NSQRT;
            end
            default: state <= S_IDLE;
          endcase
        end

        // magnitudes and signs
        S_NABS: begin
          for (int i = 0; i < 4; i++) begin
            mag[i]  <= nv[i][ACC_W-1] ? ACC_W'(-nv[i]) : nv[i];
            nneg[i] <= nv[i][ACC_W-1];
          end
          nzero <= (nv[0] == '0) && (nv[1] == '0) && (nv[2] == '0) &&
                   (nv[3] == '0);
          if ((nv[0] == '0) && (nv[1] == '0) && (nv[2] == '0) &&
              (nv[3] == '0)) begin
            state <= S_NDONE;
          end else begin
            state <= S_NSHIFT;
          end
        end

        // bring the largest magnitude into [2^30, 2^31), one bit a cycle
        S_NSHIFT: begin
          if (mag_hi) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] >> 1;
          end else if (mag_lo) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] << 1;
          end else begin
            sumsq  <= '0;
            pc     <= PC_SQ;
            pc_end <= PC_SQ_END;
            phase  <= PH_SQ;
            state  <= S_MUL;
          end
        end

        S_NSQRT: begin
          if (sge) begin
            sx <= sx - rb[63:0];
          end
          sres <= sres_nx;
          sbit <= sbit >> 2;
          scnt <= scnt - 5'd1;
          if (scnt == 5'd0) begin
            nrm   <= sres_nx[31:0];
            ci    <= 2'd0;
            rem   <= 34'(mag[0][31:0]);
            quo   <= '0;
            dcnt  <= DC_W'(FRAC_BITS);
            state <= S_NDIV;
          end
        end

        S_NDIV: begin
          rem  <= {rem_sub[32:0], 1'b0};
          quo  <= quo_nx;
          dcnt <= dcnt - DC_W'(1);
          if (dcnt == '0) begin
            nres[ci] <= nneg[ci] ? -quo_nx : quo_nx;
            quo      <= '0;
            dcnt     <= DC_W'(FRAC_BITS);
            rem      <= 34'(mag[ci + 2'd1][31:0]);
            ci       <= ci + 2'd1;
            if (ci == 2'd3) begin
              state <= S_NDONE;
            end
          end
        end

        S_NDONE: begin
          case (nsel)
            NS_ACC: begin
              if (nzero) begin
                for (int i = 0; i < 4; i++) begin
                  corr[i] <= '0;
                  acc[i]  <= '0;
                end
                pc     <= PC_P;
                pc_end <= PC_P_END;
                phase  <= PH_P;
              end else begin
                acc[0] <= '0;
                acc[1] <= -ACC_W'(nres[1]);
                acc[2] <= -ACC_W'(nres[2]);
                acc[3] <= ACC_W'(ONE_Q) - ACC_W'(nres[3]);
                pc     <= PC_F;
                pc_end <= PC_F_END;
                phase  <= PH_F;
              end
              state <= S_MUL;
            end
            NS_GRAD: begin
              for (int i = 0; i < 4; i++) acc[i] <= '0;
              if (nzero) begin
                for (int i = 0; i < 4; i++) corr[i] <= '0;
                pc     <= PC_P;
                pc_end <= PC_P_END;
                phase  <= PH_P;
              end else begin
                pc     <= PC_C;
                pc_end <= PC_C_END;
                phase  <= PH_C;
              end
              state <= S_MUL;
            end
            NS_QUAT: begin
              if (nzero) begin
                q[0] <= ONE_Q;
                q[1] <= '0;
                q[2] <= '0;
                q[3] <= '0;
              end else begin
                for (int i = 0; i < 4; i++) q[i] <= nres[i];
              end
              state <= S_OUT;
            end
            default: state <= S_IDLE;
          endcase
        end

        // hand the result to the output register once it is free
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {q[3], q[2], q[1], q[0]};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // no request is taken while a product is still in flight
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !mul_vld)
    else $error("request accepted with multiply in flight");

  // sum of squares starts only from range-limited magnitudes
  a_sq_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && phase == PH_SQ) |-> (!mag_hi && !mag_lo))
    else $error("magnitudes out of range at sum of squares");

  // the norm of a scaled vector is at least 2^30
  a_norm_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_NDIV) |-> (nrm[31:30] != 2'b00))
    else $error("norm below range");

  // a normalized component never exceeds one
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NDIV && dcnt == '0) |-> (quo_nx <= ONE_Q))
    else $error("normalized component above one");

endmodule

@@ tb/sv/imu_orientation_filter_update_unit_test.sv @@
`timescale 1ns / 100ps

module imu_orientation_filter_update_unit_test
  import iofu_pkg::*;
();

  localparam int FB = 30;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] rz, ry, rx, az, ay, ax;
  } sample_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         cfg_wen = 1'b0;
  logic         cfg_addr = REG_BETA;
  logic [31:0]  cfg_wdata = '0;

  imu_orientation_filter_update_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [30:0]        beta_q;
  logic [31:0]        dt_q;
  logic signed [31:0] att [4];

  sample_t      pending_samples [$];
  logic [127:0] expected_quats [$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  function automatic longint floor_sr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit-length scaling of a 4-vector; 0 when all zero
  function automatic bit unit4(input longint v [4], output longint o [4]);
    longint unsigned mg [4];
    longint unsigned m, sum, nr;
    m = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mg[i] = v[i] < 0 ? -v[i] : v[i];
      if (mg[i] > m) m = mg[i];
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << 31)) begin
      for (int i = 0; i < 4; i++) mg[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      for (int i = 0; i < 4; i++) mg[i] <<= 1;
      m <<= 1;
    end
    for (int i = 0; i < 4; i++) sum += mg[i] * mg[i];
    nr = root64(sum);
    for (int i = 0; i < 4; i++) begin
      o[i] = longint'((mg[i] << FB) / nr);
      if (v[i] < 0) o[i] = -o[i];
    end
    return 1;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return floor_sr(a * b, FB);
  endfunction

  function automatic logic [127:0] update_attitude(sample_t s);
    longint qw, qx, qy, qz, fx, fy, fz, rx, ry, rz, d, hi, lo, half;
    longint acc [4], an [4], g [4], gn [4], cr [4], p [4], qn [4], rs [4];
    logic [127:0] out;
    qw = att[0]; qx = att[1]; qy = att[2]; qz = att[3];
    acc[0] = 0; acc[1] = s.ax; acc[2] = s.ay; acc[3] = s.az;
    rx = s.rx; ry = s.ry; rz = s.rz;
    for (int i = 0; i < 4; i++) cr[i] = 0;
    half = 64'sd1 <<< (FB - 1);
    if (unit4(acc, an)) begin
      fx = 2 * (fmul(qx, qz) - fmul(qw, qy)) - an[1];
      fy = 2 * (fmul(qw, qx) + fmul(qy, qz)) - an[2];
      fz = 2 * (half - fmul(qx, qx) - fmul(qy, qy)) - an[3];
      g[0] = 2 * (fmul(qx, fy) - fmul(qy, fx));
      g[1] = 2 * (fmul(qz, fx) + fmul(qw, fy)) - 4 * fmul(qx, fz);
      g[2] = 2 * (fmul(qz, fy) - fmul(qw, fx)) - 4 * fmul(qy, fz);
      g[3] = 2 * (fmul(qx, fx) + fmul(qy, fy));
      if (unit4(g, gn))
        for (int i = 0; i < 4; i++) cr[i] = floor_sr(longint'(beta_q) * gn[i], 30);
    end
    p[0] = -qx * rx - qy * ry - qz * rz;
    p[1] = qw * rx + qy * rz - qz * ry;
    p[2] = qw * ry - qx * rz + qz * rx;
    p[3] = qw * rz + qx * ry - qy * rx;
    qn[0] = qw; qn[1] = qx; qn[2] = qy; qn[3] = qz;
    for (int i = 0; i < 4; i++) begin
      d = floor_sr(p[i], 13) - cr[i];
      hi = d * longint'(dt_q[31:16]);
      lo = d * longint'(dt_q[15:0]);
      qn[i] += floor_sr(hi + floor_sr(lo, 16), 16);
    end
    if (!unit4(qn, rs)) begin
      rs[0] = 64'sd1 <<< FB;
      rs[1] = 0; rs[2] = 0; rs[3] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      att[i] = rs[i][31:0];
      out[32*i +: 32] = rs[i][31:0];
    end
    return out;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h", what, got, want);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_quats.push_back(update_attitude(sample_t'(s_tdata)));
        void'(pending_samples.pop_front());
      end
      if ((!s_tvalid || s_tready) && pending_samples.size() > 0 &&
          !(s_tvalid && s_tready && pending_samples.size() == 0)) begin
        if ($urandom_range(99) < send_idle && !(s_tvalid && !s_tready)) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_samples[0];
        end
      end else if (s_tvalid && s_tready) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_idle);
      if (m_tvalid && m_tready) begin
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], '0);
        end else begin
          want = expected_quats.pop_front();
          if (m_tdata[31:0] !== want[31:0])
            report_mismatch("quat_w", m_tdata[31:0], want[31:0]);
          if (m_tdata[63:32] !== want[63:32])
            report_mismatch("quat_x", m_tdata[63:32], want[63:32]);
          if (m_tdata[95:64] !== want[95:64])
            report_mismatch("quat_y", m_tdata[95:64], want[95:64]);
          if (m_tdata[127:96] !== want[127:96])
            report_mismatch("quat_z", m_tdata[127:96], want[127:96]);
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic sample_t rand_sample(int kind);
    sample_t s;
    s = sample_t'({$urandom, $urandom, $urandom});
    if (kind == 0) begin
      // gravity near z with small rates, the well-formed bulk
      s.ax = 16'(int'($urandom_range(800)) - 400);
      s.ay = 16'(int'($urandom_range(800)) - 400);
      s.az = 16'(16000 + int'($urandom_range(2000)) - 1000);
      s.rx = 16'(int'($urandom_range(4000)) - 2000);
      s.ry = 16'(int'($urandom_range(4000)) - 2000);
      s.rz = 16'(int'($urandom_range(4000)) - 2000);
    end else if (kind == 1) begin
      s.ax = '0; s.ay = '0; s.az = '0;
    end
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_samples.size() > 0 || s_tvalid || expected_quats.size() > 0)
      @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_BETA) beta_q = val[30:0];
    else dt_q = val;
  endtask

  initial begin
    logic [31:0] betas [5];
    logic [31:0] dts [5];
    sample_t s;
    beta_q = 31'd81148039;
    dt_q   = 32'd4294967;
    att[0] = 32'sd1 <<< FB; att[1] = 0; att[2] = 0; att[3] = 0;
    betas = '{32'd81148039, 32'd0, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'd400000000};
    dts   = '{32'd4294967, 32'd0, 32'hFFFFFFFF, 32'd42949672, 32'h00012345};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and special cases at default settings
    s = '0; pending_samples.push_back(s);
    s = '0; s.rx = 16'sh7FFF; s.ry = 16'sh8000; s.rz = 16'sh7FFF;
    pending_samples.push_back(s);
    s = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    pending_samples.push_back(s);
    s = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    pending_samples.push_back(s);
    s = '0; s.az = 16'sd1; pending_samples.push_back(s);
    s = '0; s.az = -16'sd1; pending_samples.push_back(s);
    s = '0; s.ax = 16'sh7FFF; pending_samples.push_back(s);
    s = '0; s.ay = 16'sh8000; s.rz = 16'sh8000; pending_samples.push_back(s);
    for (int i = 0; i < 6; i++) pending_samples.push_back(rand_sample(0));
    wait_drained();

    // flip the orientation hard: largest sample period and beta, random samples
    write_reg(REG_DT, 32'hFFFFFFFF);
    write_reg(REG_BETA, 32'h7FFFFFFF);
    for (int i = 0; i < 8; i++) pending_samples.push_back(rand_sample(2));
    wait_drained();

    // random phases over settings and idling mixes
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_BETA, betas[ph % 5]);
      write_reg(REG_DT, dts[(ph * 3) % 5]);
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 46; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 46; end
        default: begin send_idle = 10; recv_idle = 10; end
      endcase
      for (int i = 0; i < 93; i++) begin
        int r;
        r = $urandom_range(99);
        pending_samples.push_back(rand_sample(r < 70 ? 0 : (r < 78 ? 1 : 2)));
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
